### hw/rtl/tiaacg_pkg.sv
// Package with the types, codes and polynomial step function of the audio channel.
package tiaacg_pkg;

    // Input command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_CONTROL_MODE    = 2'd0;
    localparam logic [1:0] REG_DIVIDER_SETTING = 2'd1;
    localparam logic [1:0] REG_VOLUME          = 2'd2;

    // Low mode bits: five-bit update and four-bit clock gating.
    localparam logic [1:0] GATE_NINE_BIT = 2'd0;
    localparam logic [1:0] GATE_FREE     = 2'd1;
    localparam logic [1:0] GATE_PATTERN  = 2'd2;
    localparam logic [1:0] GATE_SHIFTOUT = 2'd3;

    // High mode bits: four-bit register update.
    localparam logic [1:0] WAVE_LFSR   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_CHAIN  = 2'd2;
    localparam logic [1:0] WAVE_THREE  = 2'd3;

    // Reset values of the polynomial registers.
    localparam logic [5:0] FIVE_RESET = 6'h1f;
    localparam logic [3:0] FOUR_RESET = 4'hf;

    // Polynomial register pair.
    typedef struct packed {
        logic [5:0] five;
        logic [3:0] four;
    } poly_state_t;

    // One step of the polynomial registers for the given control mode.
    function automatic poly_state_t poly_step(input logic [3:0] mode, input poly_state_t cur);
        poly_state_t nxt;
        logic [1:0]  low;
        logic        fb5;
        logic        fb4;
        logic        clk4;
        low  = mode[1:0];
        fb5  = 1'b0;
        fb4  = 1'b0;
        clk4 = 1'b1;
        nxt  = cur;
        if (mode == 4'd0)
        begin
            nxt.five = {cur.five[4:0], 1'b1};
            nxt.four = {cur.four[2:0], 1'b1};
        end
        else
        begin
            // Five-bit register: own taps, or chained with the four-bit register.
            if (low != GATE_NINE_BIT)
            begin
                fb5 = (cur.five[2] ^ cur.five[4]) || (cur.five[4:0] == 5'd0);
            end
            else
            begin
                fb5 = (cur.five[4] ^ cur.four[3]) ||
                      ((cur.five[4:0] == 5'd0) && (cur.four == 4'd0));
            end
            nxt.five = {cur.five[4:0], fb5};

            // Clock gating of the four-bit register.
            if ((low == GATE_PATTERN) && (nxt.five[4:1] != 4'b1000))
            begin
                clk4 = 1'b0;
            end
            if ((low == GATE_SHIFTOUT) && !nxt.five[5])
            begin
                clk4 = 1'b0;
            end

            case (mode[3:2])
                WAVE_LFSR:   fb4 = (cur.four[2] ^ cur.four[3]) || (cur.four == 4'd0);
                WAVE_SQUARE: fb4 = !cur.four[0];
                WAVE_CHAIN:  fb4 = nxt.five[5];
                WAVE_THREE:  fb4 = (cur.four[2:0] == 3'b101) || !cur.four[2];
                default:     fb4 = 1'b0;
            endcase
            if (clk4)
            begin
                nxt.four = {cur.four[2:0], fb4};
            end
        end
        return nxt;
    endfunction

endpackage

### hw/rtl/tia_audio_channel_generator.sv
// A tick transfer's level is registered and shows in the cycle after its acceptance.
// Throughput: one input transfer per cycle unless stalled; loads give no result.
// The output register stalls the input only while a result waits on a stalled output.
// Reset (rst_n, asynchronous, active low) clears configuration, divider and the
// shifted-out bit, and sets all other polynomial bits; no clearing pass is needed.
module tia_audio_channel_generator
    import tiaacg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write port.
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    // Input channel.
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [8:0] state_value,
    // Output channel.
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] level
);

    logic [3:0]  control_mode_reg;
    logic [4:0]  divider_setting_reg;
    logic [3:0]  volume_reg;
    poly_state_t poly_reg;
    poly_state_t poly_next;
    poly_state_t poly_stepped;
    logic [4:0]  divider_count_reg;
    logic [4:0]  divider_count_next;
    logic        out_valid_reg;
    logic [3:0]  level_reg;
    logic [3:0]  level_next;
    logic        in_accept;
    logic        tick_accept;
    logic        load_accept;
    logic        out_free;
    logic        divider_hit;

    // Transfer qualification.
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = !out_free;
    assign in_accept   = in_valid && !in_stall;
    assign tick_accept = in_accept && (command == CMD_TICK);
    assign load_accept = in_accept && (command == CMD_LOAD);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg    <= 4'd0;
            divider_setting_reg <= 5'd0;
            volume_reg          <= 4'd0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_CONTROL_MODE:    control_mode_reg    <= cfg_data[3:0];
                REG_DIVIDER_SETTING: divider_setting_reg <= cfg_data;
                REG_VOLUME:          volume_reg          <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // Sample, divider and polynomial update for the accepted item.
    assign divider_hit  = (divider_count_reg == divider_setting_reg);
    assign poly_stepped = poly_step(control_mode_reg, poly_reg);
    assign level_next   = poly_reg.four[3] ? volume_reg : 4'd0;

    always_comb
    begin
        poly_next          = poly_reg;
        divider_count_next = divider_count_reg;
        if (load_accept)
        begin
            poly_next.five = {1'b0, state_value[4:0]};
            poly_next.four = state_value[8:5];
        end
        else if (tick_accept)
        begin
            if (divider_hit)
            begin
                poly_next          = poly_stepped;
                divider_count_next = 5'd0;
            end
            else
            begin
                divider_count_next = divider_count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg.five     <= FIVE_RESET;
            poly_reg.four     <= FOUR_RESET;
            divider_count_reg <= 5'd0;
        end
        else
        begin
            poly_reg          <= poly_next;
            divider_count_reg <= divider_count_next;
        end
    end

    // Output register; holds its result while the output is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tick_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

`ifndef NO_ASSERTIONS
    // An accepted tick always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) tick_accept |=> out_valid_reg)
        else $error("tick transfer produced no result");

    // The divider wraps to zero when it reaches its terminal value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && divider_hit) |=> (divider_count_reg == 5'd0))
        else $error("divider did not clear at terminal value");

    // A load clears the shifted-out bit of the five-bit register.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |=> !poly_reg.five[5])
        else $error("load left shifted-out bit set");

    // A load never creates a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_accept && !out_valid_reg) |=> !out_valid_reg)
        else $error("load transfer produced a result");
`endif

endmodule
